// ----- rtl/odrp_pkg.sv -----
// ----------------------------------------------------------------------------
// odrp_pkg
// Shared types, codes and the 8x8 threshold table of the dither packer.
// ----------------------------------------------------------------------------
package odrp_pkg;

  localparam int unsigned LP_W    = 12;  // line_pixels register width
  localparam int unsigned CNT_W   = 10;  // byte index and count width
  localparam int unsigned DATA_W  = 32;  // configuration data width
  localparam int unsigned ADDR_W  = 3;   // configuration byte address width

  localparam logic [LP_W-1:0] LINE_PIXELS_RESET = 12'd2400;

  typedef enum logic [0:0] {
    REG_LINE_PIXELS = 1'b0
  } reg_idx_t;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_EOL   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_EOL    = 2'd2
  } kind_t;

  // Values the configuration block hands to the datapath.
  typedef struct packed {
    logic [CNT_W-1:0] row_bytes;
  } cfg_t;

  localparam logic [7:0] THRESH_ROM [8][8] = '{
    '{8'd0,   8'd128, 8'd32,  8'd160, 8'd8,   8'd136, 8'd40,  8'd168},
    '{8'd192, 8'd64,  8'd224, 8'd96,  8'd200, 8'd72,  8'd232, 8'd104},
    '{8'd48,  8'd176, 8'd16,  8'd144, 8'd56,  8'd184, 8'd24,  8'd152},
    '{8'd240, 8'd112, 8'd208, 8'd80,  8'd248, 8'd120, 8'd216, 8'd88},
    '{8'd12,  8'd140, 8'd44,  8'd174, 8'd4,   8'd132, 8'd36,  8'd164},
    '{8'd204, 8'd76,  8'd236, 8'd108, 8'd196, 8'd68,  8'd228, 8'd100},
    '{8'd60,  8'd188, 8'd28,  8'd156, 8'd52,  8'd180, 8'd20,  8'd148},
    '{8'd252, 8'd124, 8'd210, 8'd92,  8'd244, 8'd116, 8'd212, 8'd84}
  };

endpackage

// ----- rtl/odrp_in_if.sv -----
// ----------------------------------------------------------------------------
// odrp_in_if
// Pixel request channel: grey level or end-of-line command.
// ----------------------------------------------------------------------------
interface odrp_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] cmd;
  logic [7:0] level;

  modport source (output valid, output cmd, output level, input ready);
  modport sink   (input valid, input cmd, input level, output ready);
endinterface

// ----- rtl/odrp_out_if.sv -----
// ----------------------------------------------------------------------------
// odrp_out_if
// Result request channel: row header, raster byte or end-of-line byte.
// ----------------------------------------------------------------------------
interface odrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [9:0] count;

  modport source (output valid, output kind, output data_byte, output count, input ready);
  modport sink   (input valid, input kind, input data_byte, input count, output ready);
endinterface

// ----- rtl/odrp_cfg.sv -----
// ----------------------------------------------------------------------------
// odrp_cfg
// APB-style register port holding line_pixels and the derived row length.
// ----------------------------------------------------------------------------
module odrp_cfg import odrp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [LP_W-1:0] line_pixels_r;
  logic [LP_W-1:0] line_pixels_nxt;
  logic            wr_en;
  reg_idx_t        reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    line_pixels_nxt = line_pixels_r;
    if (wr_en && (reg_idx == REG_LINE_PIXELS)) begin
      line_pixels_nxt = cfg_pwdata[LP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pixels_r <= LINE_PIXELS_RESET;
    end else begin
      line_pixels_r <= line_pixels_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LINE_PIXELS: cfg_prdata = {{(DATA_W-LP_W){1'b0}}, line_pixels_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Bytes per row is line_pixels / 8 + 1, at most 512.
  assign cfg.row_bytes   = {1'b0, line_pixels_r[LP_W-1:3]} + CNT_W'(1);

endmodule

// ----- rtl/ordered_dither_raster_packer.sv -----
// ----------------------------------------------------------------------------
// ordered_dither_raster_packer
// Ordered 8x8 dither of grey pixels, packed MSB first into raster bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries pixel requests (cmd = pixel, level = grey value) and
//   end-of-line requests. A pixel at the start of a row yields a header
//   with the bytes per row; every eighth pixel yields a full raster byte;
//   end of line yields the partial byte and the count of zero bytes that
//   would fill the row, then the line phase advances.
//   out_ch carries at most one result per request, registered, in the
//   cycle after the request is accepted.
//   The block accepts one request every cycle. The per-pixel work is one
//   table lookup, a compare and a 10-bit add and compare, all between the
//   state registers and the result register. in_ch.ready is low only while
//   a result waits in the result register and out_ch.ready is low; a
//   pixel that yields no result still waits behind it.
//   line_pixels is written through the cfg_ APB port (byte address 0) and
//   is read back there; write it only while the block is idle.
//   Synchronous active-low reset clears the line phase, packer, byte index
//   and result valid, and sets line_pixels to 2400.
// ----------------------------------------------------------------------------
module ordered_dither_raster_packer import odrp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  odrp_in_if.sink           in_ch,
  odrp_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;

  odrp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  logic [2:0]       line_phase_r, line_phase_nxt;
  logic [2:0]       bit_pos_r, bit_pos_nxt;
  logic [7:0]       partial_r, partial_nxt;
  logic [CNT_W-1:0] byte_index_r, byte_index_nxt;

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  logic             accept;
  logic             has_result;
  logic             dot;
  logic [7:0]       packed_byte;
  logic [CNT_W-1:0] index_inc;
  logic [CNT_W:0]   index_plus1;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign dot         = in_ch.level <= THRESH_ROM[line_phase_r][bit_pos_r];
  assign packed_byte = partial_r | ({dot, 7'b0} >> bit_pos_r);
  assign index_inc   = (bit_pos_r == 3'd7) ? byte_index_r + CNT_W'(1) : byte_index_r;
  // One bit wider so that an index at the top of its range compares correctly.
  assign index_plus1 = {1'b0, byte_index_r} + (CNT_W+1)'(1);

  always_comb begin
    line_phase_nxt = line_phase_r;
    bit_pos_nxt    = bit_pos_r;
    partial_nxt    = partial_r;
    byte_index_nxt = byte_index_r;
    has_result     = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;

    if (accept) begin
      if (cmd_t'(in_ch.cmd) == CMD_EOL) begin
        has_result    = 1'b1;
        out_kind_nxt  = KIND_EOL;
        out_data_nxt  = partial_r;
        if (index_plus1 < {1'b0, cfg.row_bytes}) begin
          out_count_nxt = cfg.row_bytes - index_plus1[CNT_W-1:0];
        end else begin
          out_count_nxt = '0;
        end
        line_phase_nxt = line_phase_r + 3'd1;
        bit_pos_nxt    = '0;
        partial_nxt    = '0;
        byte_index_nxt = '0;
      end else begin
        if ((byte_index_r == '0) && (bit_pos_r == 3'd0)) begin
          has_result    = 1'b1;
          out_kind_nxt  = KIND_HEADER;
          out_data_nxt  = '0;
          out_count_nxt = cfg.row_bytes;
        end
        if (bit_pos_r == 3'd7) begin
          has_result    = 1'b1;
          out_kind_nxt  = KIND_BYTE;
          out_data_nxt  = packed_byte;
          out_count_nxt = '0;
          partial_nxt   = '0;
        end else begin
          partial_nxt   = packed_byte;
        end
        bit_pos_nxt = bit_pos_r + 3'd1;
        // The row length may have shrunk since the index was last checked.
        byte_index_nxt = (index_inc >= cfg.row_bytes) ? '0 : index_inc;
      end
    end
  end

  always_comb begin
    if (accept && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_phase_r <= '0;
      bit_pos_r    <= '0;
      partial_r    <= '0;
      byte_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      line_phase_r <= line_phase_nxt;
      bit_pos_r    <= bit_pos_nxt;
      partial_r    <= partial_nxt;
      byte_index_r <= byte_index_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_data_r  <= out_data_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.data_byte = out_data_r;
  assign out_ch.count     = out_count_r;

`ifndef SYNTHESIS
  // Bits not yet reached in the current byte are always clear.
  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ((partial_r & (8'hFF >> bit_pos_r)) == 8'h00))
    else $error("packer holds bits below the current position");

  a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd_t'(in_ch.cmd) == CMD_EOL)) |=>
      (out_valid_r && (out_kind_r == KIND_EOL) && (bit_pos_r == 3'd0)
       && (byte_index_r == '0) && (partial_r == 8'h00)))
    else $error("end of line did not emit its byte and clear the packer");

  a_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd_t'(in_ch.cmd) == CMD_PIXEL) && (bit_pos_r == 3'd7)) |=>
      (out_valid_r && (out_kind_r == KIND_BYTE) && (bit_pos_r == 3'd0)))
    else $error("eighth pixel did not emit a raster byte");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered-dither raster packer. A short table of
// pixel and end-of-line requests covers headers, byte completion, row wrap,
// the largest line length and the saturated fill count. Randomized raster lines
// follow under several line lengths, with random idling on both channels and
// one long output stall. Results are checked in order against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import odrp_pkg::*;

  typedef struct {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [9:0] count;
  } raster_res_t;

  typedef struct {
    bit          wr;
    logic [11:0] lp;
    cmd_t        cmd;
    logic [7:0]  level;
    bit          typed;
    raster_res_t res;
  } step_row_t;

  localparam raster_res_t NO_RES = '{KIND_HEADER, 8'h00, 10'd0};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  odrp_in_if  in_ch ();
  odrp_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  ordered_dither_raster_packer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Predictor state.
  logic [11:0] line_pixels_q;
  logic [2:0]  phase_q;
  logic [2:0]  dot_pos_q;
  logic [7:0]  acc_byte_q;
  logic [9:0]  byte_idx_q;

  raster_res_t raster_expected [$];
  int          errors    = 0;
  int          n_results = 0;
  bit          calm      = 1'b0;
  bit          hold_req  = 1'b0;
  bit          hold_active = 1'b0;

  step_row_t directed_rows [24] = '{
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd0,   1'b1, '{KIND_HEADER, 8'h00, 10'd301}},
    '{1'b0, 12'd0,    CMD_EOL,   8'd0,   1'b1, '{KIND_EOL,    8'h80, 10'd300}},
    '{1'b1, 12'd1,    CMD_PIXEL, 8'd0,   1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd255, 1'b1, '{KIND_HEADER, 8'h00, 10'd1}},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd0,   1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd255, 1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd0,   1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd255, 1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd0,   1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd255, 1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd0,   1'b1, '{KIND_BYTE,   8'h55, 10'd0}},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd1,   1'b1, '{KIND_HEADER, 8'h00, 10'd1}},
    '{1'b0, 12'd0,    CMD_EOL,   8'd77,  1'b1, '{KIND_EOL,    8'h80, 10'd0}},
    '{1'b1, 12'd4095, CMD_PIXEL, 8'd0,   1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd255, 1'b1, '{KIND_HEADER, 8'h00, 10'd512}},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd176, 1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd16,  1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd144, 1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd56,  1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd184, 1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd24,  1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_PIXEL, 8'd153, 1'b0, NO_RES},
    // Shrinking the row under a running line leaves the byte index past its
    // end, so the fill count of the next end of line saturates at zero.
    '{1'b1, 12'd1,    CMD_PIXEL, 8'd0,   1'b0, NO_RES},
    '{1'b0, 12'd0,    CMD_EOL,   8'd200, 1'b1, '{KIND_EOL,    8'h00, 10'd0}}
  };

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic bit dither_pack(input cmd_t cmd, input logic [7:0] level,
                                     output raster_res_t res);
    int   nbytes;
    logic dot;
    bit   got;
    nbytes = int'(line_pixels_q) / 8 + 1;
    got    = 1'b0;
    res    = NO_RES;
    if (cmd == CMD_EOL) begin
      res.kind      = KIND_EOL;
      res.data_byte = acc_byte_q;
      res.count     = (int'(byte_idx_q) + 1 < nbytes) ? 10'(nbytes - 1 - int'(byte_idx_q))
                                                       : 10'd0;
      dot_pos_q  = 3'd0;
      acc_byte_q = 8'h00;
      byte_idx_q = 10'd0;
      phase_q    = phase_q + 3'd1;
      return 1'b1;
    end
    if (byte_idx_q == 10'd0 && dot_pos_q == 3'd0) begin
      res = '{KIND_HEADER, 8'h00, 10'(nbytes)};
      got = 1'b1;
    end
    dot = (level <= THRESH_ROM[phase_q][dot_pos_q]);
    acc_byte_q = acc_byte_q | (8'(dot) << (3'd7 - dot_pos_q));
    if (dot_pos_q == 3'd7) begin
      dot_pos_q  = 3'd0;
      byte_idx_q = byte_idx_q + 10'd1;
      res        = '{KIND_BYTE, acc_byte_q, 10'd0};
      got        = 1'b1;
      acc_byte_q = 8'h00;
    end else begin
      dot_pos_q = dot_pos_q + 3'd1;
    end
    if (int'(byte_idx_q) >= nbytes) begin
      byte_idx_q = 10'd0;
    end
    return got;
  endfunction

  // Biased toward the threshold that the next pixel meets, and its neighbor.
  function automatic logic [7:0] pick_level();
    logic [7:0] th;
    th = THRESH_ROM[phase_q][dot_pos_q];
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return th;
      3:       return th + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic issue_request(input cmd_t c, input logic [7:0] lv,
                               output bit got, output raster_res_t res);
    if (!calm && !hold_active && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.level <= lv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = dither_pack(c, lv, res);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (raster_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_line_pixels(input logic [11:0] lp);
    logic [DATA_W-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(4 * int'(REG_LINE_PIXELS));
    cfg_pwdata  <= DATA_W'(lp);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    line_pixels_q = lp;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== DATA_W'(lp)) begin
      note_error($sformatf("line_pixels read back %0d, expected %0d", rd, lp));
    end
  endtask

  always @(posedge clk) begin
    raster_res_t got;
    raster_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{kind_t'(out_ch.kind), out_ch.data_byte, out_ch.count};
      if (raster_expected.size() == 0) begin
        note_error($sformatf("result %0d arrived with nothing expected: kind %0d byte %02h count %0d",
                             n_results, got.kind, got.data_byte, got.count));
      end else begin
        want = raster_expected.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.count !== want.count) begin
          note_error($sformatf({"result %0d: expected kind %0d byte %02h count %0d, ",
                                "got kind %0d byte %02h count %0d"}, n_results,
                               want.kind, want.data_byte, want.count,
                               got.kind, got.data_byte, got.count));
        end
      end
      n_results++;
    end
  end

  // Result side: random stalls, one long hold-off on request, none at the end.
  initial begin
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    bit          got;
    raster_res_t res;
    logic [11:0] lp;
    int          left;
    int          npix;

    in_ch.valid <= 1'b0;
    in_ch.cmd   <= CMD_PIXEL;
    in_ch.level <= 8'd0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    line_pixels_q = LINE_PIXELS_RESET;
    phase_q       = 3'd0;
    dot_pos_q     = 3'd0;
    acc_byte_q    = 8'h00;
    byte_idx_q    = 10'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr) begin
        settle();
        program_line_pixels(directed_rows[i].lp);
      end else begin
        issue_request(directed_rows[i].cmd, directed_rows[i].level, got, res);
        if (directed_rows[i].typed) begin
          raster_expected.push_back(directed_rows[i].res);
        end else if (got) begin
          raster_expected.push_back(res);
        end
      end
    end

    // Phases end wherever the budget runs out, often mid-line, so the next
    // register write also lands under a running line.
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      calm = (ph >= 10);
      case (ph)
        2:       lp = 12'd4095;
        5:       lp = 12'd1;
        8:       lp = 12'd2400;
        default: lp = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(41, 4095))
                                                   : 12'($urandom_range(1, 40));
      endcase
      program_line_pixels(lp);
      if (ph == 0) begin
        hold_req = 1'b1;
      end
      left = 40;
      while (left > 0) begin
        if (lp <= 12'd40) begin
          npix = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(lp) + 9) : int'(lp);
        end else begin
          npix = $urandom_range(0, 30);
        end
        for (int p = 0; p < npix && left > 0; p++) begin
          issue_request(CMD_PIXEL, pick_level(), got, res);
          if (got) begin
            raster_expected.push_back(res);
          end
          left--;
        end
        if (left > 0 && $urandom_range(0, 9) != 0) begin
          issue_request(CMD_EOL, 8'($urandom_range(0, 255)), got, res);
          if (got) begin
            raster_expected.push_back(res);
          end
          left--;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/odrp_pkg.sv
rtl/odrp_in_if.sv
rtl/odrp_out_if.sv
rtl/odrp_cfg.sv
rtl/ordered_dither_raster_packer.sv
tb/tb_top.sv
